/* rtl/lav_pkg.sv */
// Shared types, constants and arithmetic helpers of the look-at view matrix block.
`default_nettype none

package lav_pkg;

  // Fraction bits of the internal unit vectors
  localparam int FRAC_BITS = 16;
  // Signed width of a unit vector component (holds +-2^FRAC_BITS)
  localparam int UW = FRAC_BITS + 2;
  // Magnitude width: covers the raw side vector (unit forward times 32-bit up)
  localparam int MW = FRAC_BITS + 33;
  // Quotient bits of the normalising division
  localparam int QB = FRAC_BITS + 2;
  // Signed operand width of the shared multiplier
  localparam int OW = 33;
  // Output entry width, Q1.16
  localparam int EW = 18;

  localparam logic [MW-1:0] SCL_HI = MW'(1) << 30;
  localparam logic [MW-1:0] SCL_LO = MW'(1) << 29;
  localparam logic [QB-1:0] Q_ONE  = QB'(1) << FRAC_BITS;
  localparam logic [1:0]    ROW_LAST = 2'd2;

  // One camera item as it travels from the front to the back
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] upv;
    logic [2:0][32:0] fwd;
    logic             fzero;
  } cam_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_MAC,
    ST_SQRT,
    ST_DIVLD,
    ST_DIV,
    ST_EMIT
  } st_t;

  typedef enum logic [1:0] {
    OP_SQ,
    OP_SIDE,
    OP_UPV,
    OP_DOT
  } op_t;

  // Next and previous component index, cyclic over three
  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [1:0] prv3(input logic [1:0] i);
    return (i == 2'd0) ? 2'd2 : i - 2'd1;
  endfunction

  // Right shift by n rounding half away from zero
  function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v, input int n);
    logic [63:0] m;
    if (n <= 0) begin
      return v;
    end
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'(1) << (n - 1))) >> n;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // Convert a unit component to Q1.16 and clamp
  function automatic logic signed [EW-1:0] to_q16(input logic signed [UW-1:0] v);
    logic signed [63:0] w;
    logic signed [63:0] r;
    w = 64'(v);
    if (FRAC_BITS > 16) begin
      r = shr_rnd(w, FRAC_BITS - 16);
    end else begin
      r = w <<< (16 - FRAC_BITS);
    end
    if (r > 64'sd65536) begin
      r = 64'sd65536;
    end else if (r < -64'sd65536) begin
      r = -64'sd65536;
    end
    return EW'(r);
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] t);
    if (t > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (t < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(t);
  endfunction

endpackage

`default_nettype wire

/* rtl/look_at_view_matrix.sv */
// Top level of the look-at view matrix block.
//
// Usage: drive the eye point, target point and up vector (signed Q16.16) on the
// in_ ports and raise start; the item transfers at a clock edge where start is
// high and busy is low. For each item the block returns three rows in order
// (side, up, negated forward), each on the out_ ports for one cycle marked by
// out_valid, with out_last_row on the third. A zero forward or side vector
// gives three zero rows with out_degenerate set.
// The first row follows two passes of scaling (one bit per cycle), a bit-serial
// square root (32 steps) and a division per component, plus the shared
// multiplier passes; a zero forward vector goes straight to the translation passes.
// Each further row follows its own translation pass of the multiplier.
// A front stage and a two-entry queue take up to three further items while the
// back end works.
// Reset (synchronous, rst_n low) empties the queue and idles the back end.
// The receiver cannot stall: each row is taken in its single valid cycle.
`default_nettype none

module look_at_view_matrix import lav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          in_eye_x,
  input  logic [31:0]          in_eye_y,
  input  logic [31:0]          in_eye_z,
  input  logic [31:0]          in_target_x,
  input  logic [31:0]          in_target_y,
  input  logic [31:0]          in_target_z,
  input  logic [31:0]          in_upvec_x,
  input  logic [31:0]          in_upvec_y,
  input  logic [31:0]          in_upvec_z,
  output logic                 out_valid,
  output logic [1:0]           out_row_index,
  output logic signed [EW-1:0] out_entry_x,
  output logic signed [EW-1:0] out_entry_y,
  output logic signed [EW-1:0] out_entry_z,
  output logic signed [31:0]   out_translation,
  output logic                 out_degenerate,
  output logic                 out_last_row
);

  cam_t q_wr;
  cam_t q_rd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  lav_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_eye_x    (in_eye_x),
    .in_eye_y    (in_eye_y),
    .in_eye_z    (in_eye_z),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .in_target_z (in_target_z),
    .in_upvec_x  (in_upvec_x),
    .in_upvec_y  (in_upvec_y),
    .in_upvec_z  (in_upvec_z),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr)
  );

  lav_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  lav_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_row_index   (out_row_index),
    .out_entry_x     (out_entry_x),
    .out_entry_y     (out_entry_y),
    .out_entry_z     (out_entry_z),
    .out_translation (out_translation),
    .out_degenerate  (out_degenerate),
    .out_last_row    (out_last_row)
  );

  // Last-row flag marks row two exactly
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == ROW_LAST)))
    else $error("last-row flag does not match row index");

  // Degenerate rows carry only zeros
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_entry_x == 0 && out_entry_y == 0 &&
                                       out_entry_z == 0 && out_translation == 0))
    else $error("degenerate row with nonzero content");

  // Rows before the last are each followed by a gap cycle
  a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_index != ROW_LAST) |=> !out_valid)
    else $error("rows emitted back to back");

endmodule

`default_nettype wire

/* rtl/lav_queue.sv */
// Two-entry queue between the front and the back.
`default_nettype none

module lav_queue import lav_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cam_t wr_data,
  input  logic pop,
  output cam_t rd_data,
  output logic full,
  output logic empty
);

  cam_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  // Write the entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);

endmodule

`default_nettype wire

/* rtl/lav_front.sv */
// Front end: accept camera items, form the forward vector and flag a zero one.
`default_nettype none

module lav_front import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_eye_x,
  input  logic [31:0] in_eye_y,
  input  logic [31:0] in_eye_z,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_z,
  input  logic [31:0] in_upvec_x,
  input  logic [31:0] in_upvec_y,
  input  logic [31:0] in_upvec_z,
  input  logic        q_full,
  output logic        q_push,
  output cam_t        q_data
);

  cam_t stg_r;
  cam_t stg_nxt;
  logic stg_v_r;
  logic stg_v_nxt;
  logic accept;

  // Hold off only while the stage is loaded and the queue cannot take it
  assign busy   = stg_v_r & q_full;
  assign accept = start & ~busy;
  assign q_push = stg_v_r & ~q_full;
  assign q_data = stg_r;

  // Form forward = target - eye at full width
  always_comb begin
    stg_nxt.eye = {in_eye_z, in_eye_y, in_eye_x};
    stg_nxt.upv = {in_upvec_z, in_upvec_y, in_upvec_x};
    stg_nxt.fwd[0] = 33'($signed(in_target_x)) - 33'($signed(in_eye_x));
    stg_nxt.fwd[1] = 33'($signed(in_target_y)) - 33'($signed(in_eye_y));
    stg_nxt.fwd[2] = 33'($signed(in_target_z)) - 33'($signed(in_eye_z));
    stg_nxt.fzero  = (stg_nxt.fwd == '0);
    stg_v_nxt      = accept | (stg_v_r & ~q_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/lav_back.sv */
// Back end: normalise, cross products and translations over one shared multiplier.
`default_nettype none

module lav_back import lav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  cam_t                 q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [1:0]           out_row_index,
  output logic signed [EW-1:0] out_entry_x,
  output logic signed [EW-1:0] out_entry_y,
  output logic signed [EW-1:0] out_entry_z,
  output logic signed [31:0]   out_translation,
  output logic                 out_degenerate,
  output logic                 out_last_row
);

  st_t  state_r;
  st_t  state_nxt;
  op_t  op_r;
  logic [1:0] idx_r;
  logic [1:0] cnt_r;
  logic [4:0] bit_r;
  logic       side_ph_r;
  logic       degen_r;
  logic       pneg_r;

  logic signed [31:0]   eye_r [3];
  logic signed [31:0]   upv_r [3];
  logic [MW-1:0]        m_r   [3];
  logic                 neg_r [3];
  logic signed [UW-1:0] fu_r  [3];
  logic signed [UW-1:0] su_r  [3];
  logic signed [UW-1:0] uu_r  [3];
  logic signed [MW:0]   sr_r  [3];
  logic signed [UW-1:0] rowv  [3][3];

  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic [63:0]        x_r;
  logic [63:0]        root_r;
  logic [31:0]        len_r;
  logic [31:0]        rem_r;
  logic [QB-1:0]      lo_r;
  logic [QB-1:0]      quo_r;
  logic signed [31:0] trans_r;

  logic [MW-1:0]         mx;
  logic [1:0]            nterms;
  logic [1:0]            sel;
  logic [1:0]            n1;
  logic [1:0]            n2;
  logic signed [OW-1:0]  mul_a;
  logic signed [OW-1:0]  mul_b;
  logic                  mul_sub;
  logic signed [2*OW-1:0] mul_p;
  logic signed [63:0]    acc_sum;
  logic                  mac_done;
  logic [63:0]           bval;
  logic [63:0]           trial;
  logic [QB+30:0]        dvd;
  logic [31:0]           dtry;
  logic                  dge;
  logic [QB-1:0]         quo_nxt;
  logic [QB-1:0]         qc;
  logic signed [UW-1:0]  unit;
  logic signed [63:0]    uu_rnd;
  logic signed [UW-1:0]  uu_c;

  // Largest magnitude of the vector being normalised
  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) begin
      mx = m_r[1];
    end
    if (m_r[2] > mx) begin
      mx = m_r[2];
    end
  end

  // Matrix rows: side, up, negated forward
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rowv[0][j] = su_r[j];
      rowv[1][j] = uu_r[j];
      rowv[2][j] = -fu_r[j];
    end
  end

  // Select multiplier operands for the current term
  always_comb begin
    sel     = (cnt_r == 2'd3) ? 2'd0 : cnt_r;
    n1      = nxt3(idx_r);
    n2      = prv3(idx_r);
    mul_sub = 1'b0;
    nterms  = 2'd3;
    mul_a   = '0;
    mul_b   = '0;
    case (op_r)
      OP_SQ: begin
        mul_a = $signed({3'b000, m_r[sel][29:0]});
        mul_b = $signed({3'b000, m_r[sel][29:0]});
      end
      OP_SIDE: begin
        nterms  = 2'd2;
        mul_sub = cnt_r[0];
        mul_a   = OW'(cnt_r[0] ? fu_r[n2] : fu_r[n1]);
        mul_b   = OW'(cnt_r[0] ? upv_r[n1] : upv_r[n2]);
      end
      OP_UPV: begin
        nterms  = 2'd2;
        mul_sub = cnt_r[0];
        mul_a   = OW'(cnt_r[0] ? su_r[n2] : su_r[n1]);
        mul_b   = OW'(cnt_r[0] ? fu_r[n1] : fu_r[n2]);
      end
      default: begin
        mul_a = OW'(rowv[(idx_r == 2'd3) ? 2'd0 : idx_r][sel]);
        mul_b = OW'(eye_r[sel]);
      end
    endcase
    mul_p    = mul_a * mul_b;
    acc_sum  = acc_r + (pneg_r ? -prod_r : prod_r);
    mac_done = (cnt_r == nterms);
  end

  // Square root step, division step and result shaping
  always_comb begin
    bval    = 64'(1) << {bit_r, 1'b0};
    trial   = root_r + bval;
    dvd     = ((QB+31)'(m_r[idx_r == 2'd3 ? 2'd0 : idx_r][29:0]) << FRAC_BITS)
              + (QB+31)'(len_r >> 1);
    dtry    = {rem_r[30:0], lo_r[QB-1]};
    dge     = (dtry >= len_r);
    quo_nxt = {quo_r[QB-2:0], dge};
    qc      = (quo_nxt > Q_ONE) ? Q_ONE : quo_nxt;
    unit    = neg_r[idx_r == 2'd3 ? 2'd0 : idx_r] ? -$signed(UW'(qc)) : $signed(UW'(qc));
    uu_rnd  = shr_rnd(acc_sum, FRAC_BITS);
    if (uu_rnd > $signed(64'(Q_ONE))) begin
      uu_c = $signed(UW'(Q_ONE));
    end else if (uu_rnd < -$signed(64'(Q_ONE))) begin
      uu_c = -$signed(UW'(Q_ONE));
    end else begin
      uu_c = UW'(uu_rnd);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.fzero ? ST_MAC : ST_SCALE;
        end
      end
      ST_LOAD:  state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (mx == '0) begin
          state_nxt = ST_MAC;
        end else if (mx < SCL_HI && mx >= SCL_LO) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          unique case (op_r)
            OP_SQ:   state_nxt = ST_SQRT;
            OP_SIDE: state_nxt = (idx_r == 2'd2) ? ST_LOAD : ST_MAC;
            OP_UPV:  state_nxt = ST_MAC;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SQRT:  state_nxt = (bit_r == 5'd0) ? ST_DIVLD : ST_SQRT;
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (bit_r == 5'd0) begin
          state_nxt = (idx_r == 2'd2) ? ST_MAC : ST_DIVLD;
        end
      end
      ST_EMIT:  state_nxt = (idx_r == ROW_LAST) ? ST_IDLE : ST_MAC;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          for (int i = 0; i < 3; i++) begin
            eye_r[i] <= $signed(q_data.eye[i]);
            upv_r[i] <= $signed(q_data.upv[i]);
            m_r[i]   <= q_data.fwd[i][32] ? MW'(-$signed(q_data.fwd[i]))
                                          : MW'(q_data.fwd[i]);
            neg_r[i] <= q_data.fwd[i][32];
            fu_r[i]  <= '0;
            su_r[i]  <= '0;
            uu_r[i]  <= '0;
          end
          side_ph_r <= 1'b0;
          degen_r   <= q_data.fzero;
          op_r      <= q_data.fzero ? OP_DOT : OP_SQ;
          idx_r     <= 2'd0;
          cnt_r     <= 2'd0;
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          m_r[i]   <= sr_r[i][MW] ? MW'(-sr_r[i]) : MW'(sr_r[i]);
          neg_r[i] <= sr_r[i][MW];
        end
        side_ph_r <= 1'b1;
      end
      ST_SCALE: begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
        if (mx == '0) begin
          // Zero-length vector: clear all rows
          degen_r <= 1'b1;
          op_r    <= OP_DOT;
          for (int i = 0; i < 3; i++) begin
            fu_r[i] <= '0;
            su_r[i] <= '0;
            uu_r[i] <= '0;
          end
        end else if (mx >= SCL_HI) begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= m_r[i] >> 1;
          end
        end else if (mx < SCL_LO) begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= m_r[i] << 1;
          end
        end else begin
          op_r <= OP_SQ;
        end
      end
      ST_MAC: begin
        if (!mac_done) begin
          prod_r <= mul_p[63:0];
          pneg_r <= mul_sub;
        end
        acc_r <= (cnt_r == 2'd0) ? 64'sd0 : acc_sum;
        cnt_r <= mac_done ? 2'd0 : cnt_r + 2'd1;
        if (mac_done) begin
          case (op_r)
            OP_SQ: begin
              x_r    <= 64'(acc_sum);
              root_r <= '0;
              bit_r  <= 5'd31;
            end
            OP_SIDE: begin
              sr_r[idx_r] <= acc_sum[MW:0];
              idx_r       <= nxt3(idx_r);
            end
            OP_UPV: begin
              uu_r[idx_r] <= uu_c;
              idx_r       <= nxt3(idx_r);
              if (idx_r == 2'd2) begin
                op_r <= OP_DOT;
              end
            end
            default: begin
              trans_r <= sat32(-shr_rnd(acc_sum, FRAC_BITS));
            end
          endcase
        end
      end
      ST_SQRT: begin
        if (x_r >= trial) begin
          x_r    <= x_r - trial;
          root_r <= (root_r >> 1) + bval;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          len_r <= (x_r >= trial) ? 32'((root_r >> 1) + bval) : 32'(root_r >> 1);
          idx_r <= 2'd0;
        end
      end
      ST_DIVLD: begin
        rem_r <= 32'(dvd >> QB);
        lo_r  <= dvd[QB-1:0];
        quo_r <= '0;
        bit_r <= 5'(QB - 1);
      end
      ST_DIV: begin
        rem_r <= dge ? dtry - len_r : dtry;
        lo_r  <= lo_r << 1;
        quo_r <= quo_nxt;
        bit_r <= bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          if (side_ph_r) begin
            su_r[idx_r] <= unit;
          end else begin
            fu_r[idx_r] <= unit;
          end
          idx_r <= nxt3(idx_r);
          op_r  <= side_ph_r ? OP_UPV : OP_SIDE;
          cnt_r <= 2'd0;
        end
      end
      ST_EMIT: begin
        idx_r <= nxt3(idx_r);
        cnt_r <= 2'd0;
      end
      default: begin
      end
    endcase
  end

  // Outputs
  always_comb begin
    q_pop           = (state_r == ST_IDLE) && !q_empty;
    out_valid       = (state_r == ST_EMIT);
    out_row_index   = idx_r;
    out_entry_x     = to_q16(rowv[(idx_r == 2'd3) ? 2'd0 : idx_r][0]);
    out_entry_y     = to_q16(rowv[(idx_r == 2'd3) ? 2'd0 : idx_r][1]);
    out_entry_z     = to_q16(rowv[(idx_r == 2'd3) ? 2'd0 : idx_r][2]);
    out_translation = trans_r;
    out_degenerate  = degen_r;
    out_last_row    = out_valid && (idx_r == ROW_LAST);
  end

endmodule

`default_nettype wire

/* bench/tb_look_at_view_matrix.sv */
// Self-checking testbench of the look-at view matrix block.
`timescale 1ns / 100ps
`default_nettype none

module tb_look_at_view_matrix import lav_pkg::*; ();

  localparam int FB = 16;
  localparam longint UNIT = 64'sd1 << FB;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] tgt;
    logic [2:0][31:0] upv;
  } camera_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [17:0] ex;
    logic [17:0] ey;
    logic [17:0] ez;
    logic [31:0] trans;
    logic        degen;
    logic        last;
  } view_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic [31:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic [31:0] in_upvec_x = '0, in_upvec_y = '0, in_upvec_z = '0;
  logic out_valid;
  logic [1:0] out_row_index;
  logic signed [EW-1:0] out_entry_x, out_entry_y, out_entry_z;
  logic signed [31:0] out_translation;
  logic out_degenerate, out_last_row;

  camera_t   pending_cams[$];
  view_row_t rows_due[$];
  bit        failed = 1'b0;
  bit        feed_done = 1'b0;
  int        send_idle_pct = 37;
  bit        hold_feed = 1'b0;

  look_at_view_matrix DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint magn(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd_shift(input longint v, input int n);
    longint m;
    m = (magn(v) + (64'sd1 << (n - 1))) >>> n;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint lim(input longint v, input longint l);
    return v > l ? l : (v < -l ? -l : v);
  endfunction

  function automatic longint int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale into [2^29, 2^30), then divide each component by the length
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, s, len, q;
    for (int i = 0; i < 3; i++) m[i] = magn(v[i]);
    mx = m[0] > m[1] ? m[0] : m[1];
    if (m[2] > mx) mx = m[2];
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // Predict the three view matrix rows of one camera
  task automatic predict_view_rows(input camera_t c);
    longint eye[3], up[3], f[3], fu[3], sr[3], su[3], uu[3], rw[3][3];
    longint dot, t;
    bit ok;
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(c.eye[i]));
      up[i]  = longint'($signed(c.upv[i]));
      f[i]   = longint'($signed(c.tgt[i])) - eye[i];
    end
    ok = unit_vec(f, fu);
    if (ok) begin
      sr[0] = fu[1] * up[2] - fu[2] * up[1];
      sr[1] = fu[2] * up[0] - fu[0] * up[2];
      sr[2] = fu[0] * up[1] - fu[1] * up[0];
      ok = unit_vec(sr, su);
    end
    if (ok) begin
      uu[0] = su[1] * fu[2] - su[2] * fu[1];
      uu[1] = su[2] * fu[0] - su[0] * fu[2];
      uu[2] = su[0] * fu[1] - su[1] * fu[0];
      for (int i = 0; i < 3; i++) begin
        rw[0][i] = su[i];
        rw[1][i] = lim(rnd_shift(uu[i], FB), UNIT);
        rw[2][i] = -fu[i];
      end
    end else begin
      for (int k = 0; k < 3; k++) for (int i = 0; i < 3; i++) rw[k][i] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot += rw[k][i] * eye[i];
      t = -rnd_shift(dot, FB);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      r.row   = 2'(k);
      r.ex    = 18'(lim(rw[k][0], 65536));
      r.ey    = 18'(lim(rw[k][1], 65536));
      r.ez    = 18'(lim(rw[k][2], 65536));
      r.trans = 32'(t);
      r.degen = !ok;
      r.last  = (k == 2);
      rows_due.push_back(r);
    end
  endtask

  function automatic camera_t mk_cam(input longint e[3], input longint g[3],
                                     input longint u[3]);
    camera_t c;
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = 32'(e[i]);
      c.tgt[i] = 32'(g[i]);
      c.upv[i] = 32'(u[i]);
    end
    return c;
  endfunction

  // Mostly modest coordinates, sometimes full range or tiny
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  // Drive one transfer per accepted start, idling at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_view_rows({in_eye_x, in_eye_y, in_eye_z, in_target_x, in_target_y,
                           in_target_z, in_upvec_x, in_upvec_y, in_upvec_z} == 0 ?
                          '0 : camera_t'{{in_eye_z, in_eye_y, in_eye_x},
                                         {in_target_z, in_target_y, in_target_x},
                                         {in_upvec_z, in_upvec_y, in_upvec_x}});
      end
      if (!start || !busy) begin
        if (pending_cams.size() > 0 && !hold_feed &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          camera_t c;
          c = pending_cams.pop_front();
          start       <= 1'b1;
          in_eye_x    <= c.eye[0];
          in_eye_y    <= c.eye[1];
          in_eye_z    <= c.eye[2];
          in_target_x <= c.tgt[0];
          in_target_y <= c.tgt[1];
          in_target_z <= c.tgt[2];
          in_upvec_x  <= c.upv[0];
          in_upvec_y  <= c.upv[1];
          in_upvec_z  <= c.upv[2];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Compare each row transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row %0d", $time, out_row_index);
        failed = 1'b1;
      end else begin
        view_row_t w, g;
        w = rows_due.pop_front();
        g = '{out_row_index, out_entry_x, out_entry_y, out_entry_z,
              out_translation, out_degenerate, out_last_row};
        if (g.row !== w.row) begin
          $display("%0t: row_index exp %0d got %0d", $time, w.row, g.row);
          failed = 1'b1;
        end
        if (g.ex !== w.ex) begin
          $display("%0t: entry_x exp %0d got %0d", $time, $signed(w.ex), $signed(g.ex));
          failed = 1'b1;
        end
        if (g.ey !== w.ey) begin
          $display("%0t: entry_y exp %0d got %0d", $time, $signed(w.ey), $signed(g.ey));
          failed = 1'b1;
        end
        if (g.ez !== w.ez) begin
          $display("%0t: entry_z exp %0d got %0d", $time, $signed(w.ez), $signed(g.ez));
          failed = 1'b1;
        end
        if (g.trans !== w.trans) begin
          $display("%0t: translation exp %0d got %0d", $time,
                   $signed(w.trans), $signed(g.trans));
          failed = 1'b1;
        end
        if (g.degen !== w.degen) begin
          $display("%0t: degenerate exp %0b got %0b", $time, w.degen, g.degen);
          failed = 1'b1;
        end
        if (g.last !== w.last) begin
          $display("%0t: last_row exp %0b got %0b", $time, w.last, g.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Fill the queue phase by phase and wait for the block to drain
  initial begin
    longint e[3], g[3], u[3];
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: classic camera, eye equals target, up parallel, zero up,
    // extremes, tiny vectors, saturating translation
    e = '{0, 0, 5 * 65536}; g = '{0, 0, 0}; u = '{0, 65536, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{65536, 2, 3}; g = e; u = '{0, 65536, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{0, 0, 0}; g = '{0, 3 * 65536, 0}; u = '{0, 65536, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{1, 2, 3}; g = '{7, -9, 4}; u = '{0, 0, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{mn, mn, mn}; g = '{mx, mx, mx}; u = '{mx, mn, mx};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{mx, mx, mx}; g = '{mn, mn, mn}; u = '{mn, mx, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{mx, mn, mx}; g = '{mx, mn, mx - 1}; u = '{1, 0, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{0, 0, 0}; g = '{1, 0, 0}; u = '{0, 0, -1};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{mn, mx, mn}; g = '{0, 0, 0}; u = '{0, 65536, 0};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{-1, -1, -1}; g = '{-1, -1, -1}; u = '{mn, mn, mn};
    pending_cams.push_back(mk_cam(e, g, u));
    e = '{100, 200, 300}; g = '{-100, 400, 50}; u = '{mx, mx, mn};
    pending_cams.push_back(mk_cam(e, g, u));

    // Let everything drain before the random phases
    while (pending_cams.size() != 0) @(negedge clk);
    hold_feed = 1'b1;
    while (start || rows_due.size() != 0) @(negedge clk);
    hold_feed = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1 ? 87 : 0);
      for (int n = 0; n < 40; n++) begin
        camera_t c;
        for (int i = 0; i < 3; i++) begin
          c.eye[i] = rnd_coord();
          c.tgt[i] = ($urandom_range(0, 19) == 0) ? c.eye[i] : rnd_coord();
          c.upv[i] = rnd_coord();
        end
        if ($urandom_range(0, 19) == 0) c.upv = '0;
        pending_cams.push_back(c);
      end
      while (pending_cams.size() != 0) @(negedge clk);
      while (start || rows_due.size() != 0) @(negedge clk);
    end
    feed_done = 1'b1;
  end

  // Finish once drained, allowing the block's latency to pass
  initial begin
    wait (feed_done);
    repeat (400) @(posedge clk);
    if (!failed && rows_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/lav_pkg.sv
rtl/lav_queue.sv
rtl/lav_front.sv
rtl/lav_back.sv
rtl/look_at_view_matrix.sv
bench/tb_look_at_view_matrix.sv
